// File: hdl/bls_pkg.sv
// ============================================================================
// bls_pkg
// Shared widths, codes and beat types of the line pixel stepper.
// ============================================================================
`timescale 1ns / 1ps

package bls_pkg;

    localparam int COORD_BITS = 16;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int DIM_BITS   = 13;
    localparam int MAX_DIM    = 4096;
    localparam int INDEX_BITS = 24;
    localparam int APB_DATA   = 32;
    localparam int APB_ADDR   = 3;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic                         operation;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_bls_in;

    typedef struct packed {
        logic                         pixel_valid;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         write_enable;
        logic [INDEX_BITS-1:0]        frame_index;
        logic                         line_done;
    } t_bls_out;

    // pixel from the stepper, before the frame test
    typedef struct packed {
        logic                         pixel_valid;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } t_bls_pix;

endpackage

// File: hdl/bresenham_line_pixel_stepper.sv
// ============================================================================
// bresenham_line_pixel_stepper
// Bresenham line stepper with frame bounds test and frame-buffer index.
//
// Every input beat gives exactly one result beat, and a beat can be taken in
// every clock cycle unless the output stalls. A beat is registered first in
// the stepper, which sets up the line or advances one pixel on the error term,
// then in the emit stage, whose 13 x 13 multiply forms the row-flipped frame
// index. A start beat yields the first pixel at once; each step beat yields
// the next pixel, with line_done on the last one. A step with no line active
// yields an all-zero result. Frame width and height sit at byte addresses 0
// and 4 of the APB port; the low 13 bits of a write are saturated to 4096. The
// user must write them only while the block is idle (not enforced by the block).
// ============================================================================
`timescale 1ns / 1ps

module bresenham_line_pixel_stepper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bls_pkg::t_bls_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bls_pkg::t_bls_out             o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bls_pkg::APB_ADDR-1:0]  paddr,
    input  logic [bls_pkg::APB_DATA-1:0]  pwdata,
    output logic [bls_pkg::APB_DATA-1:0]  prdata,
    output logic                          pready
);

    localparam int DB = bls_pkg::DIM_BITS;
    localparam int AD = bls_pkg::APB_DATA;

    logic [DB-1:0]     r_frame_width;
    logic [DB-1:0]     r_frame_height;
    logic [DB-1:0]     n_dim;
    logic              cfg_write;
    bls_pkg::t_reg_sel sel;

    logic              pix_valid;
    logic              pix_stall;
    bls_pkg::t_bls_pix pix_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign sel       = bls_pkg::t_reg_sel'(paddr[2]);

    always_comb begin
        n_dim = pwdata[DB-1:0];
        if (32'(pwdata[DB-1:0]) > 32'(bls_pkg::MAX_DIM)) begin
            n_dim = DB'(bls_pkg::MAX_DIM);
        end
        case (sel)
            bls_pkg::REG_FRAME_WIDTH:  prdata = AD'(r_frame_width);
            bls_pkg::REG_FRAME_HEIGHT: prdata = AD'(r_frame_height);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bls_pkg::WIDTH_RESET;
            r_frame_height <= bls_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            if (sel == bls_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= n_dim;
            end else begin
                r_frame_height <= n_dim;
            end
        end
    end

    bls_stepper u_stepper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (pix_valid),
        .i_stall (pix_stall),
        .o_data  (pix_data)
    );

    bls_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (pix_valid),
        .o_stall        (pix_stall),
        .i_data         (pix_data),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_data         (o_out_data)
    );

endmodule

// File: hdl/bls_stepper.sv
// ============================================================================
// bls_stepper
// Line setup and one Bresenham step per beat; holds the line state.
// ============================================================================
`timescale 1ns / 1ps

module bls_stepper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bls_pkg::t_bls_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output bls_pkg::t_bls_pix o_data
);

    localparam int CB = bls_pkg::COORD_BITS;
    localparam int EB = bls_pkg::ERR_BITS;

    logic                 r_line_active;
    logic signed [CB-1:0] r_cur_x;
    logic signed [CB-1:0] r_cur_y;
    logic signed [CB-1:0] r_major_end;
    logic signed [EB-1:0] r_error;
    logic [CB:0]          r_abs_dx;
    logic [CB:0]          r_abs_dy;
    logic                 r_x_major;
    logic                 r_minor_up;
    logic                 r_valid;
    bls_pkg::t_bls_pix    r_pix;

    logic                 n_line_active;
    logic signed [CB-1:0] n_cur_x;
    logic signed [CB-1:0] n_cur_y;
    logic signed [CB-1:0] n_major_end;
    logic signed [EB-1:0] n_error;
    logic [CB:0]          n_abs_dx;
    logic [CB:0]          n_abs_dy;
    logic                 n_x_major;
    logic                 n_minor_up;
    bls_pkg::t_bls_pix    n_pix;

    logic                 accept;
    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic [CB:0]          adx;
    logic [CB:0]          ady;
    logic                 xm;
    logic signed [EB-1:0] twice_dx;
    logic signed [EB-1:0] twice_dy;
    logic signed [CB-1:0] major_cur;
    logic                 last;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_pix;

    always_comb begin
        dx  = {i_data.end_x[CB-1], i_data.end_x} - {i_data.start_x[CB-1], i_data.start_x};
        dy  = {i_data.end_y[CB-1], i_data.end_y} - {i_data.start_y[CB-1], i_data.start_y};
        adx = dx[CB] ? (~dx + 1'b1) : dx;
        ady = dy[CB] ? (~dy + 1'b1) : dy;
        xm  = (ady <= adx);
        twice_dx = $signed({1'b0, r_abs_dx, 1'b0});
        twice_dy = $signed({1'b0, r_abs_dy, 1'b0});

        n_line_active = r_line_active;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_major_end   = r_major_end;
        n_error       = r_error;
        n_abs_dx      = r_abs_dx;
        n_abs_dy      = r_abs_dy;
        n_x_major     = r_x_major;
        n_minor_up    = r_minor_up;

        if (i_data.operation == bls_pkg::OP_START) begin
            n_abs_dx   = adx;
            n_abs_dy   = ady;
            n_x_major  = xm;
            n_minor_up = (dx[CB] && dy[CB]) || (dx > 0 && dy > 0);
            if (xm) begin
                n_error = $signed({1'b0, ady, 1'b0}) - $signed({2'b00, adx});
                if (!dx[CB]) begin
                    n_cur_x = i_data.start_x;
                    n_cur_y = i_data.start_y;
                    n_major_end = i_data.end_x;
                end else begin
                    n_cur_x = i_data.end_x;
                    n_cur_y = i_data.end_y;
                    n_major_end = i_data.start_x;
                end
            end else begin
                n_error = $signed({1'b0, adx, 1'b0}) - $signed({2'b00, ady});
                if (!dy[CB]) begin
                    n_cur_x = i_data.start_x;
                    n_cur_y = i_data.start_y;
                    n_major_end = i_data.end_y;
                end else begin
                    n_cur_x = i_data.end_x;
                    n_cur_y = i_data.end_y;
                    n_major_end = i_data.start_y;
                end
            end
        end else if (r_line_active) begin
            if (r_x_major) begin
                n_cur_x = r_cur_x + 1'b1;
                if (r_error < 0) begin
                    n_error = r_error + twice_dy;
                end else begin
                    n_cur_y = r_minor_up ? (r_cur_y + 1'b1) : (r_cur_y - 1'b1);
                    n_error = r_error + (twice_dy - twice_dx);
                end
            end else begin
                n_cur_y = r_cur_y + 1'b1;
                if (r_error <= 0) begin
                    n_error = r_error + twice_dx;
                end else begin
                    n_cur_x = r_minor_up ? (r_cur_x + 1'b1) : (r_cur_x - 1'b1);
                    n_error = r_error + (twice_dx - twice_dy);
                end
            end
        end

        major_cur = n_x_major ? n_cur_x : n_cur_y;
        last      = (major_cur >= n_major_end);

        n_pix = '0;
        if (i_data.operation == bls_pkg::OP_START || r_line_active) begin
            n_line_active     = !last;
            n_pix.pixel_valid = 1'b1;
            n_pix.x           = n_cur_x;
            n_pix.y           = n_cur_y;
            n_pix.last        = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_valid       <= 1'b0;
        end else if (accept) begin
            r_line_active <= n_line_active;
            r_valid       <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_major_end <= n_major_end;
            r_error     <= n_error;
            r_abs_dx    <= n_abs_dx;
            r_abs_dy    <= n_abs_dy;
            r_x_major   <= n_x_major;
            r_minor_up  <= n_minor_up;
            r_pix       <= n_pix;
        end
    end

endmodule

// File: hdl/bls_emit.sv
// ============================================================================
// bls_emit
// Frame bounds test and row-flipped frame-buffer index; output register.
// ============================================================================
`timescale 1ns / 1ps

module bls_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  bls_pkg::t_bls_pix              i_data,
    input  logic [bls_pkg::DIM_BITS-1:0]   i_frame_width,
    input  logic [bls_pkg::DIM_BITS-1:0]   i_frame_height,
    output logic                           o_valid,
    input  logic                           i_stall,
    output bls_pkg::t_bls_out              o_data
);

    localparam int CB = bls_pkg::COORD_BITS;
    localparam int DB = bls_pkg::DIM_BITS;
    localparam int IB = bls_pkg::INDEX_BITS;

    logic              r_valid;
    bls_pkg::t_bls_out r_out;
    bls_pkg::t_bls_out n_out;

    logic                 load;
    logic signed [CB:0]   x_ext;
    logic signed [CB:0]   y_ext;
    logic signed [CB:0]   w_ext;
    logic signed [CB:0]   h_ext;
    logic                 in_frame;
    logic [DB-1:0]        row;
    logic [2*DB-1:0]      prod;

    assign load    = i_valid && !o_stall;
    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        x_ext    = {i_data.x[CB-1], i_data.x};
        y_ext    = {i_data.y[CB-1], i_data.y};
        w_ext    = $signed({{(CB+1-DB){1'b0}}, i_frame_width});
        h_ext    = $signed({{(CB+1-DB){1'b0}}, i_frame_height});
        in_frame = i_data.pixel_valid && (x_ext >= 0) && (x_ext < w_ext)
                   && (y_ext >= 0) && (y_ext < h_ext);
        row      = i_frame_height - 1'b1 - i_data.y[DB-1:0];
        prod     = row * i_frame_width;

        n_out              = '0;
        n_out.pixel_valid  = i_data.pixel_valid;
        n_out.pixel_x      = i_data.x;
        n_out.pixel_y      = i_data.y;
        n_out.write_enable = in_frame;
        n_out.line_done    = i_data.last;
        if (in_frame) begin
            n_out.frame_index = prod[IB-1:0] + IB'(i_data.x[DB-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

// File: tb/bresenham_line_pixel_stepper_tb.sv
// ============================================================================
// bresenham_line_pixel_stepper_tb
// Self-checking bench for the line pixel stepper. A directed table covers idle
// steps, single-pixel lines, dropped lines, coordinate extremes and the frame
// edges. Random lines with short, well-formed step runs follow, plus stray and
// broken sequences, across several frame sizes written over APB. Every result
// beat is checked against its table row or a cycle-free line tracer, with random
// gaps and stalls on both channels; two long output hold-offs back up the input.
// ============================================================================
`timescale 1ns / 1ps

module bresenham_line_pixel_stepper_tb;

    localparam int CB = bls_pkg::COORD_BITS;
    localparam int DB = bls_pkg::DIM_BITS;
    localparam int AD = bls_pkg::APB_DATA;
    localparam int AA = bls_pkg::APB_ADDR;
    localparam int IB = bls_pkg::INDEX_BITS;

    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 250;
    localparam int N_PHASES    = 8;
    localparam int PHASE_BEATS = 230;
    localparam int N_SCRIPT    = 26;

    localparam bls_pkg::t_bls_out IDLE_PIX = '0;

    typedef struct {
        bls_pkg::t_bls_in  beat;
        bit                typed;
        bls_pkg::t_bls_out want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_stall;
    bls_pkg::t_bls_in  in_data = '0;
    logic              o_out_valid;
    logic              out_stall = 1'b0;
    bls_pkg::t_bls_out o_out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [AA-1:0]     paddr = '0;
    logic [AD-1:0]     pwdata = '0;
    logic [AD-1:0]     prdata;
    logic              pready;

    t_row              tx_q[$];
    bls_pkg::t_bls_out pending_pixels[$];
    bls_pkg::t_bls_out due_pix;
    bls_pkg::t_bls_out traced_pix;
    bit       offered = 1'b0;
    int       gap_left = 0;
    bit       no_idle = 1'b0;
    bit       hold_req = 1'b0;
    bit       holding = 1'b0;
    int       fail_cnt = 0;
    int       cycle_cnt = 0;

    // line tracer state
    logic                 line_on = 1'b0;
    logic signed [CB-1:0] pos_x = '0;
    logic signed [CB-1:0] pos_y = '0;
    logic signed [CB-1:0] major_stop = '0;
    int                   err_acc = 0;
    int                   run_dx = 0;
    int                   run_dy = 0;
    logic                 along_x = 1'b0;
    logic                 minor_inc = 1'b0;
    logic [DB-1:0]        frame_w = bls_pkg::WIDTH_RESET;
    logic [DB-1:0]        frame_h = bls_pkg::HEIGHT_RESET;

    t_row line_script [N_SCRIPT] = '{
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, IDLE_PIX},
        '{'{bls_pkg::OP_START, 16'sd5, 16'sd7, 16'sd5, 16'sd7}, 1'b1,
          '{1'b1, 16'sd5, 16'sd7, 1'b1, 24'd302085, 1'b1}},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, IDLE_PIX},
        '{'{bls_pkg::OP_START, 16'sd0, 16'sd0, 16'sd3, 16'sd1}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, IDLE_PIX},
        '{'{bls_pkg::OP_START, 16'sd10, 16'sd20, 16'sd7, 16'sd14}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_START, -16'sd5, -16'sd5, 16'sd2, -16'sd9}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_START, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF}, 1'b1,
          '{1'b1, 16'sh8000, 16'sh8000, 1'b0, 24'd0, 1'b0}},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_START, 16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_START, 16'sd639, 16'sd479, 16'sd639, 16'sd479}, 1'b1,
          '{1'b1, 16'sd639, 16'sd479, 1'b1, 24'd639, 1'b1}},
        '{'{bls_pkg::OP_START, 16'sd640, 16'sd0, 16'sd640, 16'sd0}, 1'b1,
          '{1'b1, 16'sd640, 16'sd0, 1'b0, 24'd0, 1'b1}},
        '{'{bls_pkg::OP_START, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{1'b1, 16'sd0, 16'sd0, 1'b1, 24'd306560, 1'b1}},
        '{'{bls_pkg::OP_START, 16'sd0, -16'sd1, 16'sd0, -16'sd1}, 1'b1,
          '{1'b1, 16'sd0, -16'sd1, 1'b0, 24'd0, 1'b1}},
        '{'{bls_pkg::OP_START, 16'sd3, 16'sd5, 16'sd3, 16'sd1}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_START, 16'sd0, 16'sd0, 16'sd2, 16'sd5}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX},
        '{'{bls_pkg::OP_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, IDLE_PIX}
    };

    logic [AD-1:0] phase_w [N_PHASES] = '{
        32'd640, 32'd4096, 32'd1, 32'hFFFF_F005, 32'd0, 32'd200, 32'd4097, 32'd0
    };
    logic [AD-1:0] phase_h [N_PHASES] = '{
        32'd480, 32'd4096, 32'd1, 32'h0000_1FFF, 32'd300, 32'd0, 32'd57, 32'd0
    };

    bresenham_line_pixel_stepper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        if (no_idle || holding)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DB-1:0] clamp_dim(input logic [AD-1:0] value);
        logic [DB-1:0] v;
        v = value[DB-1:0];
        return (v > bls_pkg::MAX_DIM) ? DB'(bls_pkg::MAX_DIM) : v;
    endfunction

    function automatic bls_pkg::t_bls_out advance_line(input bls_pkg::t_bls_in b);
        int                dx;
        int                dy;
        int                px;
        int                py;
        int                w;
        int                h;
        logic              last;
        bls_pkg::t_bls_out pix;
        pix = '0;
        if (b.operation == bls_pkg::OP_START) begin
            dx = int'($signed(b.end_x)) - int'($signed(b.start_x));
            dy = int'($signed(b.end_y)) - int'($signed(b.start_y));
            run_dx = (dx < 0) ? -dx : dx;
            run_dy = (dy < 0) ? -dy : dy;
            minor_inc = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
            along_x = run_dy <= run_dx;
            if (along_x) begin
                err_acc = 2 * run_dy - run_dx;
                if (dx >= 0) begin
                    pos_x = b.start_x; pos_y = b.start_y; major_stop = b.end_x;
                end else begin
                    pos_x = b.end_x; pos_y = b.end_y; major_stop = b.start_x;
                end
            end else begin
                err_acc = 2 * run_dx - run_dy;
                if (dy >= 0) begin
                    pos_x = b.start_x; pos_y = b.start_y; major_stop = b.end_y;
                end else begin
                    pos_x = b.end_x; pos_y = b.end_y; major_stop = b.start_y;
                end
            end
        end else if (!line_on) begin
            return '0;
        end else if (along_x) begin
            pos_x = pos_x + 16'sd1;
            if (err_acc < 0) begin
                err_acc += 2 * run_dy;
            end else begin
                pos_y = minor_inc ? pos_y + 16'sd1 : pos_y - 16'sd1;
                err_acc += 2 * (run_dy - run_dx);
            end
        end else begin
            pos_y = pos_y + 16'sd1;
            if (err_acc <= 0) begin
                err_acc += 2 * run_dx;
            end else begin
                pos_x = minor_inc ? pos_x + 16'sd1 : pos_x - 16'sd1;
                err_acc += 2 * (run_dx - run_dy);
            end
        end
        last = (along_x ? pos_x : pos_y) >= major_stop;
        line_on = !last;
        px = int'(pos_x);
        py = int'(pos_y);
        w = int'(frame_w);
        h = int'(frame_h);
        pix.pixel_valid = 1'b1;
        pix.pixel_x = pos_x;
        pix.pixel_y = pos_y;
        pix.line_done = last;
        if (px >= 0 && px < w && py >= 0 && py < h) begin
            pix.write_enable = 1'b1;
            pix.frame_index = IB'((h - 1 - py) * w + px);
        end
        return pix;
    endfunction

    function automatic bls_pkg::t_bls_in junk_beat(input bls_pkg::t_op op);
        bls_pkg::t_bls_in b;
        b.operation = op;
        b.start_x = CB'($urandom);
        b.start_y = CB'($urandom);
        b.end_x = CB'($urandom);
        b.end_y = CB'($urandom);
        return b;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s expected %0d got %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    // input channel: drive at the falling edge, hold until taken
    always @(negedge i_clk) begin
        if (!offered) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (tx_q.size() > 0) begin
                in_valid <= 1'b1;
                in_data <= tx_q[0].beat;
                offered = 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) begin
            traced_pix = advance_line(tx_q[0].beat);
            pending_pixels.push_back(tx_q[0].typed ? tx_q[0].want : traced_pix);
            void'(tx_q.pop_front());
            offered = 1'b0;
            gap_left = idle_len();
        end
    end

    // output channel stall pattern, with an occasional long hold-off
    initial begin : rx_pacing
        int n;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding = 1'b1;
                n = HOLD_CYCLES;
            end else begin
                n = idle_len();
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                holding = 1'b0;
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with nothing expected: %h", o_out_data);
                fail_cnt++;
            end else begin
                due_pix = pending_pixels.pop_front();
                check_field("pixel_valid", due_pix.pixel_valid, o_out_data.pixel_valid);
                check_field("pixel_x", $signed(due_pix.pixel_x), $signed(o_out_data.pixel_x));
                check_field("pixel_y", $signed(due_pix.pixel_y), $signed(o_out_data.pixel_y));
                check_field("write_enable", due_pix.write_enable, o_out_data.write_enable);
                check_field("frame_index", due_pix.frame_index, o_out_data.frame_index);
                check_field("line_done", due_pix.line_done, o_out_data.line_done);
            end
        end
    end

    task automatic apb_write(input bls_pkg::t_reg_sel sel, input logic [AD-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (sel == bls_pkg::REG_FRAME_WIDTH)
            frame_w = clamp_dim(value);
        else
            frame_h = clamp_dim(value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_read(input bls_pkg::t_reg_sel sel, input logic [DB-1:0] want_v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {sel, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== AD'(want_v)) begin
            $error("prdata expected %0d got %0d", want_v, prdata);
            fail_cnt++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        while (tx_q.size() != 0 || pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_beat(input bls_pkg::t_bls_in b);
        t_row r;
        r.beat = b;
        r.typed = 1'b0;
        r.want = IDLE_PIX;
        tx_q.push_back(r);
    endtask

    task automatic run_lines(input int quota);
        int               sent;
        int               sx;
        int               sy;
        int               dx;
        int               dy;
        int               span;
        int               steps;
        bls_pkg::t_bls_in b;
        sent = 0;
        while (sent < quota) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 19) == 0) begin
                send_beat(junk_beat(bls_pkg::OP_STEP));
                sent++;
            end else begin
                b = junk_beat(bls_pkg::OP_START);
                if ($urandom_range(0, 3) != 0) begin
                    sx = int'($urandom_range(0, int'(frame_w) + 32)) - 16;
                    sy = int'($urandom_range(0, int'(frame_h) + 32)) - 16;
                    b.start_x = CB'(sx);
                    b.start_y = CB'(sy);
                end
                if ($urandom_range(0, 9) != 0) begin
                    b.end_x = b.start_x + CB'(int'($urandom_range(0, 48)) - 24);
                    b.end_y = b.start_y + CB'(int'($urandom_range(0, 48)) - 24);
                end
                dx = int'($signed(b.end_x)) - int'($signed(b.start_x));
                dy = int'($signed(b.end_y)) - int'($signed(b.start_y));
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                span = (dx > dy) ? dx : dy;
                if ($urandom_range(0, 4) != 0) begin
                    steps = (span < 64) ? span : 64;
                    if ($urandom_range(0, 3) == 0)
                        steps += $urandom_range(1, 2);
                end else begin
                    steps = $urandom_range(0, 6);
                end
                send_beat(b);
                sent++;
                repeat (steps) begin
                    send_beat(junk_beat(bls_pkg::OP_STEP));
                    sent++;
                end
            end
            while (tx_q.size() > 2)
                @(negedge i_clk);
        end
    endtask

    initial begin : main_flow
        int ph;
        logic [AD-1:0] w_val;
        logic [AD-1:0] h_val;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_read(bls_pkg::REG_FRAME_WIDTH, bls_pkg::WIDTH_RESET);
        apb_read(bls_pkg::REG_FRAME_HEIGHT, bls_pkg::HEIGHT_RESET);

        foreach (line_script[i])
            tx_q.push_back(line_script[i]);

        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drain();
            w_val = (ph == N_PHASES - 1) ? AD'($urandom_range(1, bls_pkg::MAX_DIM))
                                         : phase_w[ph];
            h_val = (ph == N_PHASES - 1) ? AD'($urandom_range(1, bls_pkg::MAX_DIM))
                                         : phase_h[ph];
            apb_write(bls_pkg::REG_FRAME_WIDTH, w_val);
            apb_write(bls_pkg::REG_FRAME_HEIGHT, h_val);
            apb_read(bls_pkg::REG_FRAME_WIDTH, frame_w);
            apb_read(bls_pkg::REG_FRAME_HEIGHT, frame_h);
            if (ph == 1 || ph == 5)
                hold_req = 1'b1;
            run_lines(PHASE_BEATS);
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: bresenham_line_pixel_stepper.f
hdl/bls_pkg.sv
hdl/bls_stepper.sv
hdl/bls_emit.sv
hdl/bresenham_line_pixel_stepper.sv
tb/bresenham_line_pixel_stepper_tb.sv
